@@ hdl/tmi_pkg.sv @@
package tmi_pkg;

  localparam int unsigned TAPE_CELLS = 4096;
  localparam int unsigned LOOP_DEPTH = 64;

  localparam int unsigned TAPE_AW = $clog2(TAPE_CELLS);
  localparam int unsigned STK_AW  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(LOOP_DEPTH + 1);

  localparam logic [TAPE_AW-1:0] PTR_LAST  = TAPE_AW'(TAPE_CELLS - 1);
  localparam logic [CNT_W-1:0]   CNT_DEPTH = CNT_W'(LOOP_DEPTH);

  // Program symbols.
  localparam logic [7:0] SYM_EXIT    = 8'h21;  // '!'
  localparam logic [7:0] SYM_ERROR   = 8'h3F;  // '?'
  localparam logic [7:0] SYM_COMMENT = 8'h22;  // '"'
  localparam logic [7:0] SYM_RIGHT   = 8'h3E;  // '>'
  localparam logic [7:0] SYM_LEFT    = 8'h3C;  // '<'
  localparam logic [7:0] SYM_INC     = 8'h2B;  // '+'
  localparam logic [7:0] SYM_DEC     = 8'h2D;  // '-'
  localparam logic [7:0] SYM_READ    = 8'h2C;  // ','
  localparam logic [7:0] SYM_WRITE   = 8'h2E;  // '.'
  localparam logic [7:0] SYM_READ_CH = 8'h72;  // 'r'
  localparam logic [7:0] SYM_WRITE_CH = 8'h77; // 'w'
  localparam logic [7:0] SYM_OPEN    = 8'h5B;  // '['
  localparam logic [7:0] SYM_CLOSE   = 8'h5D;  // ']'

  // Run status codes.
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_EXIT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic               en;
    logic [TAPE_AW-1:0] addr;
    logic [31:0]        data;
  } tape_wr_t;

  typedef struct packed {
    logic              en;
    logic [STK_AW-1:0] addr;
    logic [15:0]       data;
  } stack_wr_t;

endpackage

@@ hdl/tmi_tape.sv @@
module tmi_tape
  import tmi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [TAPE_AW-1:0] rd_addr_i,
  input  tape_wr_t           wr_i,
  output logic [31:0]        cell_o,
  output logic               clearing_o
);

  logic [31:0]        mem [TAPE_CELLS];
  logic [31:0]        rd_q;
  logic               fwd_q;
  logic [31:0]        fwd_data_q;
  logic               clr_q;
  logic [TAPE_AW-1:0] clr_addr_q;

  logic               we;
  logic [TAPE_AW-1:0] wa;
  logic [31:0]        wd;

  // The clearing pass owns the write port until every cell holds zero.
  always_comb begin
    if (clr_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end else begin
      we = wr_i.en;
      wa = wr_i.addr;
      wd = wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (rd_en_i) begin
        fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == PTR_LAST) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  assign cell_o     = fwd_q ? fwd_data_q : rd_q;
  assign clearing_o = clr_q;

endmodule

@@ hdl/tmi_stack.sv @@
module tmi_stack
  import tmi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [STK_AW-1:0] rd_addr_i,
  input  stack_wr_t         wr_i,
  output logic [15:0]       top_o
);

  logic [15:0] mem [LOOP_DEPTH];
  logic [15:0] rd_q;
  logic        fwd_q;
  logic [15:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_i.data;
    end
  end

  // A push in the same cycle writes the entry that becomes the new top.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign top_o = fwd_q ? fwd_data_q : rd_q;

endmodule

@@ hdl/tape_machine_interpreter_unit.sv @@
// Tape-machine interpreter: one program symbol per transaction, one result per symbol.
// A symbol is taken every cycle while the result side keeps up; its tape cell and
// loop-stack top are read from single-port-read memories as it is accepted, and it
// executes in the execute stage once the result register can take its result, which
// is then registered there. A cell written by one symbol and read by the next is forwarded
// around the memory. After reset the tape is cleared one cell per cycle, all 4096 cells,
// and in_ready_o stays low until that pass is done.
module tape_machine_interpreter_unit
  import tmi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         symbol_i,
  input  logic [15:0]        next_position_i,
  input  logic signed [31:0] read_value_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_value_o,
  output logic               out_is_char_o,
  output logic               jump_valid_o,
  output logic [15:0]        jump_target_o,
  output logic [1:0]         status_o
);

  // Architectural state.
  logic [TAPE_AW-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               com_q, com_d;
  logic [1:0]         st_q, st_d;

  // Execute stage.
  logic        x_valid_q;
  logic [7:0]  x_sym_q;
  logic [15:0] x_npos_q;
  logic [31:0] x_rval_q;

  // Result register.
  logic        res_valid_q;
  logic        ov_q, ochar_q, jv_q;
  logic [31:0] oval_q;
  logic [15:0] jt_q;
  logic [1:0]  ost_q;

  logic        ov_d, ochar_d, jv_d;
  logic [31:0] oval_d;
  logic [15:0] jt_d;

  logic        accept, x_done, run, clearing;
  logic        tape_we, stk_we;
  logic [31:0] tape_wd;
  logic [31:0] cell_rd;
  logic [15:0] top;
  tape_wr_t    tape_wr;
  stack_wr_t   stk_wr;
  logic [TAPE_AW-1:0] tape_rd_addr;
  logic [CNT_W-1:0]   cnt_sel;
  logic [STK_AW-1:0]  stk_rd_addr;

  assign x_done     = x_valid_q && (!res_valid_q || res_ready_i);
  assign in_ready_o = !clearing && (!x_valid_q || x_done);
  assign accept     = in_valid_i && in_ready_o;
  assign run        = (st_q == ST_RUN) && ((x_sym_q == SYM_COMMENT) || !com_q);

  always_comb begin
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    com_d   = com_q;
    st_d    = st_q;
    tape_we = 1'b0;
    tape_wd = cell_rd;
    stk_we  = 1'b0;
    ov_d    = 1'b0;
    oval_d  = '0;
    ochar_d = 1'b0;
    jv_d    = 1'b0;
    jt_d    = '0;
    if (x_valid_q && run) begin
      unique case (x_sym_q)
        SYM_EXIT:    st_d = ST_EXIT;
        SYM_ERROR:   st_d = ST_ERR;
        SYM_COMMENT: com_d = !com_q;
        SYM_RIGHT:   ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
        SYM_LEFT:    ptr_d = (ptr_q == '0) ? PTR_LAST : ptr_q - 1'b1;
        SYM_INC: begin
          tape_we = 1'b1;
          tape_wd = cell_rd + 32'd1;
        end
        SYM_DEC: begin
          tape_we = 1'b1;
          tape_wd = cell_rd - 32'd1;
        end
        SYM_READ: begin
          tape_we = 1'b1;
          tape_wd = x_rval_q;
        end
        SYM_READ_CH: begin
          tape_we = 1'b1;
          tape_wd = {cell_rd[31:8], x_rval_q[7:0]};
        end
        SYM_WRITE: begin
          ov_d   = 1'b1;
          oval_d = cell_rd;
        end
        SYM_WRITE_CH: begin
          ov_d    = 1'b1;
          ochar_d = 1'b1;
          oval_d  = {24'd0, cell_rd[7:0]};
        end
        SYM_OPEN: begin
          if (cnt_q >= CNT_DEPTH) begin
            st_d = ST_ERR;
          end else begin
            stk_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
        end
        SYM_CLOSE: begin
          if (cnt_q == '0) begin
            st_d = ST_ERR;
          end else if (cell_rd != '0) begin
            jv_d = 1'b1;
            jt_d = top;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // The next symbol reads at the pointer and stack depth left by the one now executing.
  assign tape_rd_addr = x_done ? ptr_d : ptr_q;
  assign cnt_sel      = x_done ? cnt_d : cnt_q;
  assign stk_rd_addr  = STK_AW'(cnt_sel - CNT_W'(1));

  assign tape_wr.en   = x_done && tape_we;
  assign tape_wr.addr = ptr_q;
  assign tape_wr.data = tape_wd;

  assign stk_wr.en   = x_done && stk_we;
  assign stk_wr.addr = STK_AW'(cnt_q);
  assign stk_wr.data = x_npos_q;

  tmi_tape u_tape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (tape_rd_addr),
    .wr_i       (tape_wr),
    .cell_o     (cell_rd),
    .clearing_o (clearing)
  );

  tmi_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (stk_rd_addr),
    .wr_i      (stk_wr),
    .top_o     (top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      com_q       <= 1'b0;
      st_q        <= ST_RUN;
      x_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (x_done) begin
        ptr_q <= ptr_d;
        cnt_q <= cnt_d;
        com_q <= com_d;
        st_q  <= st_d;
      end
      if (accept) begin
        x_valid_q <= 1'b1;
      end else if (x_done) begin
        x_valid_q <= 1'b0;
      end
      if (x_done) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_sym_q  <= symbol_i;
      x_npos_q <= next_position_i;
      x_rval_q <= read_value_i;
    end
    if (x_done) begin
      ov_q    <= ov_d;
      oval_q  <= oval_d;
      ochar_q <= ochar_d;
      jv_q    <= jv_d;
      jt_q    <= jt_d;
      ost_q   <= st_d;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = ov_q;
  assign out_value_o   = oval_q;
  assign out_is_char_o = ochar_q;
  assign jump_valid_o  = jv_q;
  assign jump_target_o = jt_q;
  assign status_o      = ost_q;

  // Once the program has exited or failed, its status never changes again.
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_RUN) |=> (st_q == $past(st_q)))
    else $error("run status left a final state");

  // The loop stack never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_DEPTH)
    else $error("loop stack count beyond depth");

  // State only moves when an executing symbol retires.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !x_done |=> ($stable(ptr_q) && $stable(cnt_q) && $stable(com_q)))
    else $error("interpreter state changed without a retiring symbol");

  // A jump is only requested by a symbol that ran, and never with an output value.
  a_jump_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && jump_valid_o) |-> ((status_o == ST_RUN) && !out_valid_o))
    else $error("jump reported with a stopped program or an output value");

  // No symbol is taken while the tape is still being cleared.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept)
    else $error("symbol accepted during tape clearing");

endmodule
